// File: hw/rtl/lqsm_pkg.sv
// Package for the log query subsequence matcher.
// Holds the transaction types, action codes and the internal operation type.
// No dependencies.
package lqsm_pkg;

  localparam int ValueWidth = 64;

  localparam logic [2:0] ACT_CLEAR     = 3'd0;
  localparam logic [2:0] ACT_ADD_CAND  = 3'd1;
  localparam logic [2:0] ACT_ADD_LTYPE = 3'd2;
  localparam logic [2:0] ACT_BEGIN     = 3'd3;
  localparam logic [2:0] ACT_VAR       = 3'd4;
  localparam logic [2:0] ACT_END       = 3'd5;

  typedef struct packed {
    logic [2:0]                   action;
    logic signed [ValueWidth-1:0] value;
    logic                         starts_new_var;
  } item_t;

  typedef struct packed {
    logic matched;
    logic logtype_ok;
    logic vars_ok;
    logic query_overflow;
  } result_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_CLEAR,
    OP_ADD_CAND,
    OP_ADD_LTYPE,
    OP_BEGIN,
    OP_VAR,
    OP_END
  } op_t;

  typedef struct packed {
    op_t                          op;
    logic signed [ValueWidth-1:0] value;
    logic                         starts_new_var;
  } queue_entry_t;

endpackage

// File: hw/rtl/lqsm_front.sv
// Front end of the matcher: accepts transactions and classifies each action.
// Depends on lqsm_pkg; feeds lqsm_queue.
module lqsm_front
  import lqsm_pkg::*;
(
  input  logic         start,
  output logic         busy,
  input  item_t        item,
  input  logic         queue_full,
  output logic         push,
  output queue_entry_t entry
);

  op_t op;

  always_comb begin
    case (item.action)
      ACT_CLEAR:     op = OP_CLEAR;
      ACT_ADD_CAND:  op = OP_ADD_CAND;
      ACT_ADD_LTYPE: op = OP_ADD_LTYPE;
      ACT_BEGIN:     op = OP_BEGIN;
      ACT_VAR:       op = OP_VAR;
      ACT_END:       op = OP_END;
      default:       op = OP_NONE;
    endcase
  end

  assign busy                 = queue_full;
  assign push                 = start && !queue_full && (op != OP_NONE);
  assign entry.op             = op;
  assign entry.value          = item.value;
  assign entry.starts_new_var = item.starts_new_var;

endmodule

// File: hw/rtl/lqsm_queue.sv
// Two-entry queue between the front end and the execution unit.
// Depends on lqsm_pkg for the entry type.
module lqsm_queue
  import lqsm_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  queue_entry_t push_entry,
  input  logic         pop,
  output logic         full,
  output logic         not_empty,
  output queue_entry_t head
);

  queue_entry_t entries [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

// File: hw/rtl/lqsm_back.sv
// Execution unit of the matcher: query tables, match state and result register.
// Depends on lqsm_pkg; takes operations from lqsm_queue.
module lqsm_back
  import lqsm_pkg::*;
#(
  parameter int QUERY_VARS_MAX = 8,
  parameter int CANDIDATES_MAX = 32,
  parameter int LOGTYPES_MAX   = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         op_valid,
  input  queue_entry_t q,
  output logic         done,
  output result_t      result
);

  localparam int CW  = $clog2(CANDIDATES_MAX + 1);
  localparam int CIW = (CANDIDATES_MAX > 1) ? $clog2(CANDIDATES_MAX) : 1;
  localparam int QCW = $clog2(QUERY_VARS_MAX + 1);
  localparam int SW  = (QUERY_VARS_MAX > 1) ? $clog2(QUERY_VARS_MAX) : 1;
  localparam int LCW = $clog2(LOGTYPES_MAX + 1);
  localparam int LIW = (LOGTYPES_MAX > 1) ? $clog2(LOGTYPES_MAX) : 1;

  logic signed [ValueWidth-1:0] cand_values [CANDIDATES_MAX];
  logic [SW-1:0]                cand_slots  [CANDIDATES_MAX];
  logic signed [ValueWidth-1:0] logtypes    [LOGTYPES_MAX];

  logic [CW-1:0]  cand_count;
  logic [QCW-1:0] query_var_count;
  logic [LCW-1:0] logtype_count;
  logic           logtype_hit;
  logic [QCW-1:0] match_position;
  logic           overflow;
  logic           cur_dropped;

  logic           opens_var;
  logic           var_full;
  logic           cand_room;
  logic           cand_write;
  logic [SW-1:0]  cand_slot;
  logic [QCW-1:0] qvc_minus1;
  logic           ltype_write;
  logic           cand_hit;
  logic           ltype_hit;
  logic           vars_ok;

  assign opens_var  = q.starts_new_var || (query_var_count == '0);
  assign var_full   = (query_var_count >= QCW'(QUERY_VARS_MAX));
  assign cand_room  = (cand_count < CW'(CANDIDATES_MAX));
  assign qvc_minus1 = query_var_count - QCW'(1);
  assign cand_slot  = opens_var ? query_var_count[SW-1:0] : qvc_minus1[SW-1:0];
  assign cand_write = op_valid && (q.op == OP_ADD_CAND) && cand_room &&
                      (opens_var ? !var_full : !cur_dropped);
  assign ltype_write = op_valid && (q.op == OP_ADD_LTYPE) &&
                       (logtype_count < LCW'(LOGTYPES_MAX));
  assign vars_ok    = (match_position >= query_var_count);

  always_comb begin
    cand_hit = 1'b0;
    for (int i = 0; i < CANDIDATES_MAX; i++) begin
      if ((CW'(i) < cand_count) && (cand_slots[i] == match_position[SW-1:0]) &&
          (cand_values[i] == q.value)) begin
        cand_hit = 1'b1;
      end
    end
  end

  always_comb begin
    ltype_hit = 1'b0;
    for (int i = 0; i < LOGTYPES_MAX; i++) begin
      if ((LCW'(i) < logtype_count) && (logtypes[i] == q.value)) begin
        ltype_hit = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cand_write) begin
      cand_values[cand_count[CIW-1:0]] <= q.value;
      cand_slots[cand_count[CIW-1:0]]  <= cand_slot;
    end
    if (ltype_write) begin
      logtypes[logtype_count[LIW-1:0]] <= q.value;
    end
  end

  always_ff @(posedge clk) begin
    result.matched        <= logtype_hit && vars_ok;
    result.logtype_ok     <= logtype_hit;
    result.vars_ok        <= vars_ok;
    result.query_overflow <= overflow;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cand_count      <= '0;
      query_var_count <= '0;
      logtype_count   <= '0;
      logtype_hit     <= 1'b0;
      match_position  <= '0;
      overflow        <= 1'b0;
      cur_dropped     <= 1'b0;
      done            <= 1'b0;
    end else begin
      done <= op_valid && (q.op == OP_END);
      if (op_valid) begin
        case (q.op)
          OP_CLEAR: begin
            cand_count      <= '0;
            query_var_count <= '0;
            logtype_count   <= '0;
            logtype_hit     <= 1'b0;
            match_position  <= '0;
            overflow        <= 1'b0;
            cur_dropped     <= 1'b0;
          end
          OP_ADD_CAND: begin
            if (opens_var) begin
              if (var_full) begin
                overflow    <= 1'b1;
                cur_dropped <= 1'b1;
              end else begin
                query_var_count <= query_var_count + QCW'(1);
                cur_dropped     <= 1'b0;
                if (!cand_room) begin
                  overflow <= 1'b1;
                end
              end
            end else if (cur_dropped || !cand_room) begin
              overflow <= 1'b1;
            end
            if (cand_write) begin
              cand_count <= cand_count + CW'(1);
            end
          end
          OP_ADD_LTYPE: begin
            if (ltype_write) begin
              logtype_count <= logtype_count + LCW'(1);
            end else begin
              overflow <= 1'b1;
            end
          end
          OP_BEGIN: begin
            logtype_hit    <= ltype_hit;
            match_position <= '0;
          end
          OP_VAR: begin
            if ((match_position < query_var_count) && cand_hit) begin
              match_position <= match_position + QCW'(1);
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule

// File: hw/rtl/log_query_subsequence_matcher_unit.sv
// Top level of the log query subsequence matcher.
// Depends on lqsm_pkg, lqsm_front, lqsm_queue and lqsm_back.
//
// A transaction is taken on a rising edge where start is high and busy is low;
// one may be taken every cycle. An end-of-message transaction produces its
// result through the queue and the result register, on result with done
// high for one cycle, and the receiver cannot hold it off. Every other action
// produces no result. The execution unit sets the cost of each step; it
// compares the incoming value against the whole candidate or logtype table.
module log_query_subsequence_matcher_unit
  import lqsm_pkg::*;
#(
  parameter int QUERY_VARS_MAX = 8,
  parameter int CANDIDATES_MAX = 32,
  parameter int LOGTYPES_MAX   = 16
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  input  item_t   item,
  output logic    done,
  output result_t result
);

  logic         push;
  queue_entry_t push_entry;
  logic         queue_full;
  logic         queue_not_empty;
  queue_entry_t head;

  lqsm_front u_front (
    .start      (start),
    .busy       (busy),
    .item       (item),
    .queue_full (queue_full),
    .push       (push),
    .entry      (push_entry)
  );

  lqsm_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (queue_not_empty),
    .full       (queue_full),
    .not_empty  (queue_not_empty),
    .head       (head)
  );

  lqsm_back #(
    .QUERY_VARS_MAX (QUERY_VARS_MAX),
    .CANDIDATES_MAX (CANDIDATES_MAX),
    .LOGTYPES_MAX   (LOGTYPES_MAX)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .op_valid (queue_not_empty),
    .q        (head),
    .done     (done),
    .result   (result)
  );

endmodule
